>>> rtl/core/rls_pkg.sv
// Shared types, constants and codes of the LED run-light sequencer.
`default_nettype none

package rls_pkg;

    // Strip geometry.
    localparam int LED_COUNT = 16;
    localparam int LED_IDX_W = $clog2(LED_COUNT);
    localparam int STEP_W    = $clog2(LED_COUNT + 1);

    // Field and register widths.
    localparam int OPCODE_W     = 2;
    localparam int HUE_W        = 8;
    localparam int LED_SEL_W    = 4;
    localparam int LVL_W        = 8;
    localparam int SAT_W        = 8;
    localparam int PHASE_W      = 2;
    localparam int MIN_W        = 7;
    localparam int FULL_W       = 7;
    localparam int HOLD_TICKS_W = 16;
    localparam int HOLD_W       = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int RAMP_W       = ((STEP_W > MIN_W) ? STEP_W : MIN_W) + 1;

    // Register reset values.
    localparam logic [MIN_W-1:0]        MIN_LEVEL_RST  = MIN_W'(10);
    localparam logic [FULL_W-1:0]       FULL_LEVEL_RST = FULL_W'(64);
    localparam logic [HOLD_TICKS_W-1:0] HOLD_TICKS_RST = HOLD_TICKS_W'(800);

    // Saturation selection by brightness.
    localparam logic [LVL_W-1:0] VAL_LOW_LIM = LVL_W'(22);
    localparam logic [LVL_W-1:0] VAL_MID_LIM = LVL_W'(34);
    localparam logic [SAT_W-1:0] SAT_OFF     = SAT_W'(0);
    localparam logic [SAT_W-1:0] SAT_LOW     = SAT_W'(127);
    localparam logic [SAT_W-1:0] SAT_MID     = SAT_W'(191);
    localparam logic [SAT_W-1:0] SAT_HIGH    = SAT_W'(255);

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK = 2'd0,
        OP_TRIG = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT = 2'd0,
        PH_FILL = 2'd1,
        PH_ON   = 2'd2,
        PH_FADE = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LEVEL  = 2'd0,
        CFG_FULL_LEVEL = 2'd1,
        CFG_HOLD_TICKS = 2'd2,
        CFG_RUN_UPWARD = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [MIN_W-1:0]        min_level;
        logic [FULL_W-1:0]       full_level;
        logic [HOLD_TICKS_W-1:0] hold_ticks;
        logic                    run_upward;
    } t_cfg;

    typedef struct packed {
        t_opcode              opcode;
        logic [HUE_W-1:0]     trigger_hue;
        logic [LED_SEL_W-1:0] led_index;
    } t_in_item;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [LVL_W-1:0] value;
        t_phase           phase;
        logic             rearm;
    } t_out_item;

    // Two write ports into the brightness store: previous LED and current LED.
    typedef struct packed {
        logic                 prev_we;
        logic [LED_IDX_W-1:0] prev_addr;
        logic [LVL_W-1:0]     prev_data;
        logic                 cur_we;
        logic [LED_IDX_W-1:0] cur_addr;
        logic [LVL_W-1:0]     cur_data;
    } t_store_wr;

endpackage

`default_nettype wire

>>> rtl/core/rls_in_if.sv
// Input channel of the run-light sequencer: valid, ready and one command beat.
`default_nettype none

interface rls_in_if;
    logic                                valid;
    logic                                ready;
    rls_pkg::t_opcode                    opcode;
    logic [rls_pkg::HUE_W-1:0]           trigger_hue;
    logic [rls_pkg::LED_SEL_W-1:0]       led_index;

    modport source (output valid, output opcode, output trigger_hue, output led_index,
                    input ready);
    modport sink   (input valid, input opcode, input trigger_hue, input led_index,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/rls_out_if.sv
// Output channel of the run-light sequencer: valid, ready and one result beat.
`default_nettype none

interface rls_out_if;
    logic                            valid;
    logic                            ready;
    logic [rls_pkg::HUE_W-1:0]       hue;
    logic [rls_pkg::SAT_W-1:0]       saturation;
    logic [rls_pkg::LVL_W-1:0]       value;
    logic [rls_pkg::PHASE_W-1:0]     phase;
    logic                            rearm;

    modport source (output valid, output hue, output saturation, output value,
                    output phase, output rearm, input ready);
    modport sink   (input valid, input hue, input saturation, input value,
                    input phase, input rearm, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rls_store.sv
// Per-LED brightness registers with two write ports and one read port.
`default_nettype none

module rls_store (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rls_pkg::t_store_wr                i_wr,
    input  wire logic [rls_pkg::LED_IDX_W-1:0]     i_rd_addr,
    output logic [rls_pkg::LVL_W-1:0]              o_rd_data
);

    logic [rls_pkg::LVL_W-1:0] r_level [rls_pkg::LED_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rls_pkg::LED_COUNT; i++) begin
                r_level[i] <= '0;
            end
        end else begin
            if (i_wr.prev_we) begin
                r_level[i_wr.prev_addr] <= i_wr.prev_data;
            end
            if (i_wr.cur_we) begin
                r_level[i_wr.cur_addr] <= i_wr.cur_data;
            end
        end
    end

    assign o_rd_data = r_level[i_rd_addr];

endmodule

`default_nettype wire

>>> rtl/core/rls_core.sv
// Phase sequencer: state update, store writes and result formation for one beat.
`default_nettype none

module rls_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire rls_pkg::t_in_item                 i_item,
    input  wire rls_pkg::t_cfg                     i_cfg,
    output rls_pkg::t_store_wr                     o_wr,
    output logic [rls_pkg::LED_IDX_W-1:0]          o_rd_addr,
    input  wire logic [rls_pkg::LVL_W-1:0]         i_rd_data,
    output rls_pkg::t_out_item                     o_res
);

    rls_pkg::t_phase                     r_phase, n_phase;
    logic [rls_pkg::STEP_W-1:0]          r_step, n_step;
    logic [rls_pkg::HOLD_W-1:0]          r_hold, n_hold;
    logic [rls_pkg::HUE_W-1:0]           r_hue, n_hue;

    logic [rls_pkg::STEP_W-1:0]          step_inc;
    logic [rls_pkg::STEP_W-1:0]          step_dec;
    logic                                step_in_range;
    logic                                step_at_end;
    logic [rls_pkg::RAMP_W-1:0]          ramp;
    logic                                rd_in_range;
    logic [rls_pkg::LVL_W-1:0]           rd_value;
    rls_pkg::t_store_wr                  wr;

    // Maps a run step to the LED it drives, in the configured direction.
    function automatic logic [rls_pkg::LED_IDX_W-1:0] led_of_step(
        input logic [rls_pkg::STEP_W-1:0] step,
        input logic                       upward
    );
        logic [rls_pkg::LED_IDX_W-1:0] s;
        s = step[rls_pkg::LED_IDX_W-1:0];
        return upward ? (rls_pkg::LED_IDX_W'(rls_pkg::LED_COUNT - 1) - s) : s;
    endfunction

    assign step_inc      = r_step + rls_pkg::STEP_W'(1);
    assign step_dec      = r_step - rls_pkg::STEP_W'(1);
    assign step_in_range = r_step < rls_pkg::STEP_W'(rls_pkg::LED_COUNT);
    assign step_at_end   = step_inc >= rls_pkg::STEP_W'(rls_pkg::LED_COUNT);
    assign ramp          = rls_pkg::RAMP_W'(r_step) + rls_pkg::RAMP_W'(i_cfg.min_level);

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        n_hold  = r_hold;
        n_hue   = r_hue;
        unique case (i_item.opcode)
            rls_pkg::OP_TICK: begin
                unique case (r_phase)
                    rls_pkg::PH_FILL: begin
                        if (step_at_end) begin
                            n_step  = rls_pkg::STEP_W'(rls_pkg::LED_COUNT - 1);
                            n_hold  = '0;
                            n_phase = rls_pkg::PH_ON;
                        end else begin
                            n_step = step_inc;
                        end
                    end
                    rls_pkg::PH_ON: begin
                        if (r_hold > rls_pkg::HOLD_W'(i_cfg.hold_ticks)) begin
                            n_hold  = '0;
                            n_step  = '0;
                            n_phase = rls_pkg::PH_FADE;
                        end else begin
                            n_hold = r_hold + rls_pkg::HOLD_W'(1);
                        end
                    end
                    rls_pkg::PH_FADE: begin
                        if (step_at_end) begin
                            n_step  = rls_pkg::STEP_W'(rls_pkg::LED_COUNT);
                            n_phase = rls_pkg::PH_WAIT;
                        end else begin
                            n_step = step_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            rls_pkg::OP_TRIG: begin
                if (r_phase == rls_pkg::PH_WAIT) begin
                    n_hue   = i_item.trigger_hue;
                    n_step  = '0;
                    n_phase = rls_pkg::PH_FILL;
                end
            end
            default: begin
            end
        endcase
    end

    // Store writes and result.
    always_comb begin
        wr          = '0;
        o_res       = '0;
        if (i_item.opcode == rls_pkg::OP_TICK && step_in_range) begin
            unique case (r_phase)
                rls_pkg::PH_FILL: begin
                    wr.cur_we   = 1'b1;
                    wr.cur_addr = led_of_step(r_step, i_cfg.run_upward);
                    if (ramp > rls_pkg::RAMP_W'(i_cfg.full_level)) begin
                        // The first LED of the run has no previous LED.
                        wr.prev_we   = r_step != '0;
                        wr.prev_addr = led_of_step(step_dec, i_cfg.run_upward);
                        wr.prev_data = rls_pkg::LVL_W'(i_cfg.full_level);
                        wr.cur_data  = {i_cfg.full_level, 1'b0};
                    end else begin
                        wr.cur_data = rls_pkg::LVL_W'(ramp);
                    end
                end
                rls_pkg::PH_FADE: begin
                    wr.cur_we   = 1'b1;
                    wr.cur_addr = led_of_step(r_step, i_cfg.run_upward);
                    wr.cur_data = '0;
                end
                default: begin
                end
            endcase
        end
        o_res.hue   = n_hue;
        o_res.phase = n_phase;
        o_res.rearm = (i_item.opcode == rls_pkg::OP_TICK) &&
                      (r_phase == rls_pkg::PH_FADE) && step_at_end;
        o_res.value = rd_value;
        priority if (rd_value == '0) begin
            o_res.saturation = rls_pkg::SAT_OFF;
        end else if (rd_value < rls_pkg::VAL_LOW_LIM) begin
            o_res.saturation = rls_pkg::SAT_LOW;
        end else if (rd_value < rls_pkg::VAL_MID_LIM) begin
            o_res.saturation = rls_pkg::SAT_MID;
        end else begin
            o_res.saturation = rls_pkg::SAT_HIGH;
        end
    end

    assign rd_in_range = 32'(i_item.led_index) < 32'(rls_pkg::LED_COUNT);
    assign o_rd_addr   = rls_pkg::LED_IDX_W'(i_item.led_index);
    assign rd_value    = (i_item.opcode == rls_pkg::OP_READ && rd_in_range) ? i_rd_data : '0;

    always_comb begin
        o_wr         = wr;
        o_wr.prev_we = wr.prev_we && i_en;
        o_wr.cur_we  = wr.cur_we && i_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rls_pkg::PH_WAIT;
            r_step  <= '0;
            r_hold  <= '0;
            r_hue   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_hold  <= n_hold;
            r_hue   <= n_hue;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/led_run_light_sequencer.sv
// Top level of the LED run-light sequencer: input register, sequencer, output register.
// An accepted beat is held in the input register, and its result is then registered in the
// output register, where it stays until the sink takes it.
// Throughput: one beat per cycle while the sink is ready; input and output registers form a
// two-stage pipeline, and the state update plus one store access fit between them.
// Reset (synchronous, active low) empties both stages, sets the phase to waiting,
// clears the step, hold count, hue and every LED level, and loads the register defaults.
`default_nettype none

module led_run_light_sequencer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    rls_in_if.sink                                  i_in,
    rls_out_if.source                               o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [rls_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rls_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers. They must be written only while the pipeline is empty; the block does not enforce this.
    rls_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_level  <= rls_pkg::MIN_LEVEL_RST;
            r_cfg.full_level <= rls_pkg::FULL_LEVEL_RST;
            r_cfg.hold_ticks <= rls_pkg::HOLD_TICKS_RST;
            r_cfg.run_upward <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (rls_pkg::t_cfg_idx'(i_cfg_idx))
                rls_pkg::CFG_MIN_LEVEL:  r_cfg.min_level  <= i_cfg_data[rls_pkg::MIN_W-1:0];
                rls_pkg::CFG_FULL_LEVEL: r_cfg.full_level <= i_cfg_data[rls_pkg::FULL_W-1:0];
                rls_pkg::CFG_HOLD_TICKS: r_cfg.hold_ticks <= i_cfg_data;
                rls_pkg::CFG_RUN_UPWARD: r_cfg.run_upward <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Stage one holds the accepted beat. It advances into the output register
    // whenever that register is empty or its beat is being taken this cycle. The input side
    // accepts while stage one is empty or advancing, so one beat can wait behind a stalled result.
    logic                r_in_vld;
    rls_pkg::t_in_item   r_in;
    logic                r_out_vld;
    rls_pkg::t_out_item  r_out;
    logic                adv;
    logic                in_take;

    assign adv        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.opcode      <= i_in.opcode;
            r_in.trigger_hue <= i_in.trigger_hue;
            r_in.led_index   <= i_in.led_index;
        end
    end

    // Sequencer and LED store. The state and the store change only when the beat in
    // stage one moves on, so each beat acts exactly once and reads see every earlier
    // write.
    rls_pkg::t_store_wr                   store_wr;
    logic [rls_pkg::LED_IDX_W-1:0]        rd_addr;
    logic [rls_pkg::LVL_W-1:0]            rd_data;
    rls_pkg::t_out_item                   res;

    rls_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_item    (r_in),
        .i_cfg     (r_cfg),
        .o_wr      (store_wr),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_res     (res)
    );

    rls_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (store_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register. It holds its beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.hue        = r_out.hue;
    assign o_out.saturation = r_out.saturation;
    assign o_out.value      = r_out.value;
    assign o_out.phase      = r_out.phase;
    assign o_out.rearm      = r_out.rearm;

endmodule

`default_nettype wire

>>> rtl/core/rls_chk.sv
// Port-level checker of the run-light sequencer and its bind to the top level.
`default_nettype none

module rls_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [rls_pkg::HUE_W-1:0]        i_out_hue,
    input wire logic [rls_pkg::SAT_W-1:0]        i_out_saturation,
    input wire logic [rls_pkg::LVL_W-1:0]        i_out_value,
    input wire logic [rls_pkg::PHASE_W-1:0]      i_out_phase,
    input wire logic                             i_out_rearm
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hue) &&
        $stable(i_out_saturation) && $stable(i_out_value) && $stable(i_out_phase) &&
        $stable(i_out_rearm))
        else $error("result beat changed while stalled");

    // The rearm pulse comes with the return to waiting.
    a_rearm_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_rearm |-> i_out_phase == rls_pkg::PH_WAIT)
        else $error("rearm outside the end of fade-out");

    // A dark LED has no saturation, a lit one always has some.
    a_sat_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_value == '0) == (i_out_saturation == rls_pkg::SAT_OFF)))
        else $error("saturation does not match brightness");

    // Saturation takes one of four levels, chosen by brightness.
    a_sat_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_value != '0 |->
        (i_out_value < rls_pkg::VAL_LOW_LIM && i_out_saturation == rls_pkg::SAT_LOW) ||
        (i_out_value >= rls_pkg::VAL_LOW_LIM && i_out_value < rls_pkg::VAL_MID_LIM &&
         i_out_saturation == rls_pkg::SAT_MID) ||
        (i_out_value >= rls_pkg::VAL_MID_LIM && i_out_saturation == rls_pkg::SAT_HIGH))
        else $error("saturation level wrong for brightness");

endmodule

bind led_run_light_sequencer rls_chk u_rls_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_hue        (o_out.hue),
    .i_out_saturation (o_out.saturation),
    .i_out_value      (o_out.value),
    .i_out_phase      (o_out.phase),
    .i_out_rearm      (o_out.rearm)
);

`default_nettype wire
